### hw/rtl/vmfe_pkg.sv
// ----------------------------------------------------------------------------
// vmfe_pkg
// Shared types and constants for the Euler YXZ view matrix pipeline.
// ----------------------------------------------------------------------------
package vmfe_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_SHIFT = 14;
  localparam logic signed [COEF_BITS-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [POS_BITS-1:0]  pos_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    pos_t   pos_x;
    pos_t   pos_y;
    pos_t   pos_z;
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
  } in_t;

  typedef struct packed {
    coef_t u_x;
    coef_t u_y;
    coef_t u_z;
    coef_t v_x;
    coef_t v_y;
    coef_t v_z;
    coef_t w_x;
    coef_t w_y;
    coef_t w_z;
    pos_t  trans_u;
    pos_t  trans_v;
    pos_t  trans_w;
  } out_t;

  // basis entries in row order: u, v, w
  typedef coef_t basis_t [9];
  typedef pos_t  vec_t [3];

  // sine and cosine of the three angles
  typedef struct packed {
    coef_t s1;
    coef_t c1;
    coef_t s2;
    coef_t c2;
    coef_t s3;
    coef_t c3;
  } trig_t;

  // pipeline stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic coef_t q14_mul(coef_t a, coef_t b);
    logic signed [2*COEF_BITS-1:0] p;
    p = a * b;
    return COEF_BITS'(p >>> FRAC_SHIFT);
  endfunction

  function automatic coef_t sat_basis(logic signed [COEF_BITS:0] x);
    logic signed [COEF_BITS:0] one_w;
    one_w = (COEF_BITS+1)'(ONE_Q14);
    if (x > one_w) return ONE_Q14;
    else if (x < -one_w) return -ONE_Q14;
    else return COEF_BITS'(x);
  endfunction

endpackage

### hw/rtl/vmfe_if.sv
// ----------------------------------------------------------------------------
// vmfe_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface vmfe_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/vmfe_trig.sv
// ----------------------------------------------------------------------------
// vmfe_trig
// Quarter-wave sine ROM lookup giving registered sine and cosine of one angle.
// ----------------------------------------------------------------------------
module vmfe_trig
  import vmfe_pkg::*;
#(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic   clk,
  input  logic   en,
  input  angle_t angle,
  output coef_t  sin_q,
  output coef_t  cos_q
);

  localparam int QBITS = SINE_INDEX_BITS - 2;
  localparam int QSIZE = 1 << QBITS;
  localparam int TSIZE = QSIZE + 1;
  localparam real STEP = 3.14159265358979323846 / (2.0 * real'(QSIZE));

  typedef logic [COEF_BITS-2:0] mag_t;
  typedef mag_t tab_t [TSIZE];

  function automatic tab_t build_tab();
    tab_t t;
    real  a;
    for (int k = 0; k < TSIZE; k++) begin
      a = $sin(STEP * real'(k));
      t[k] = mag_t'($rtoi(a * 16384.0 + 0.5));
    end
    return t;
  endfunction

  localparam tab_t ROM = build_tab();

  logic [SINE_INDEX_BITS-1:0] phase;
  logic [SINE_INDEX_BITS-1:0] phase_c;
  logic [QBITS:0] idx_s;
  logic [QBITS:0] idx_c;
  mag_t mag_s;
  mag_t mag_c;
  logic neg_s;
  logic neg_c;

  generate
    if (ANGLE_BITS >= SINE_INDEX_BITS) begin : g_trunc
      assign phase = angle[ANGLE_BITS-1 -: SINE_INDEX_BITS];
    end else begin : g_pad
      assign phase = {angle, {(SINE_INDEX_BITS-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign phase_c = phase + SINE_INDEX_BITS'(QSIZE);

  // odd quadrants run the table backward
  always_comb begin
    idx_s = phase[QBITS] ? (QBITS+1)'(QSIZE) - {1'b0, phase[QBITS-1:0]}
                         : {1'b0, phase[QBITS-1:0]};
    idx_c = phase_c[QBITS] ? (QBITS+1)'(QSIZE) - {1'b0, phase_c[QBITS-1:0]}
                           : {1'b0, phase_c[QBITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_s <= ROM[idx_s];
      mag_c <= ROM[idx_c];
      neg_s <= phase[QBITS+1];
      neg_c <= phase_c[QBITS+1];
    end
  end

  assign sin_q = neg_s ? -coef_t'({1'b0, mag_s}) : coef_t'({1'b0, mag_s});
  assign cos_q = neg_c ? -coef_t'({1'b0, mag_c}) : coef_t'({1'b0, mag_c});

endmodule

### hw/rtl/vmfe_basis.sv
// ----------------------------------------------------------------------------
// vmfe_basis
// Two multiply stages forming the saturated YXZ rotation basis in Q1.14.
// ----------------------------------------------------------------------------
module vmfe_basis
  import vmfe_pkg::*;
(
  input  logic   clk,
  input  logic   en_a,
  input  logic   en_b,
  input  trig_t  tr,
  output basis_t basis
);

  // first stage: two-factor products
  coef_t c1c3, s1s2, c2s3, c1s2, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
  coef_t s2_a, s3_a;

  always_ff @(posedge clk) begin
    if (en_a) begin
      c1c3 <= q14_mul(tr.c1, tr.c3);
      s1s2 <= q14_mul(tr.s1, tr.s2);
      c2s3 <= q14_mul(tr.c2, tr.s3);
      c1s2 <= q14_mul(tr.c1, tr.s2);
      c3s1 <= q14_mul(tr.c3, tr.s1);
      c1s3 <= q14_mul(tr.c1, tr.s3);
      c2c3 <= q14_mul(tr.c2, tr.c3);
      s1s3 <= q14_mul(tr.s1, tr.s3);
      c2s1 <= q14_mul(tr.c2, tr.s1);
      c1c2 <= q14_mul(tr.c1, tr.c2);
      s2_a <= tr.s2;
      s3_a <= tr.s3;
    end
  end

  // second stage: triple products, sums, clamp
  always_ff @(posedge clk) begin
    if (en_b) begin
      basis[0] <= sat_basis(17'(c1c3) + 17'(q14_mul(s1s2, s3_a)));
      basis[1] <= c2s3;
      basis[2] <= sat_basis(17'(q14_mul(c1s2, s3_a)) - 17'(c3s1));
      basis[3] <= sat_basis(17'(q14_mul(c3s1, s2_a)) - 17'(c1s3));
      basis[4] <= c2c3;
      basis[5] <= sat_basis(17'(q14_mul(c1c3, s2_a)) + 17'(s1s3));
      basis[6] <= c2s1;
      basis[7] <= sat_basis(-17'(s2_a));
      basis[8] <= c1c2;
    end
  end

endmodule

### hw/rtl/vmfe_translate.sv
// ----------------------------------------------------------------------------
// vmfe_translate
// Basis times position products, then dot sums with shift, negate, saturate.
// ----------------------------------------------------------------------------
module vmfe_translate
  import vmfe_pkg::*;
(
  input  logic   clk,
  input  logic   en_a,
  input  logic   en_b,
  input  basis_t basis,
  input  vec_t   pos,
  output out_t   res
);

  localparam int PROD_BITS = COEF_BITS + POS_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int SH_BITS   = SUM_BITS - FRAC_SHIFT;

  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [SH_BITS:0]     neg_t;

  prod_t  prod [9];
  basis_t basis_a;

  function automatic pos_t finish(prod_t a, prod_t b, prod_t c);
    sum_t s;
    neg_t t;
    s = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
    t = -(SH_BITS+1)'(s >>> FRAC_SHIFT);
    if (t > (SH_BITS+1)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    else if (t < (SH_BITS+1)'(-33'sh80000000)) return 32'sh80000000;
    else return POS_BITS'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[3*r+c] <= PROD_BITS'(basis[3*r+c]) * PROD_BITS'(pos[c]);
        end
      end
      basis_a <= basis;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      res.u_x     <= basis_a[0];
      res.u_y     <= basis_a[1];
      res.u_z     <= basis_a[2];
      res.v_x     <= basis_a[3];
      res.v_y     <= basis_a[4];
      res.v_z     <= basis_a[5];
      res.w_x     <= basis_a[6];
      res.w_y     <= basis_a[7];
      res.w_z     <= basis_a[8];
      res.trans_u <= finish(prod[0], prod[1], prod[2]);
      res.trans_v <= finish(prod[3], prod[4], prod[5]);
      res.trans_w <= finish(prod[6], prod[7], prod[8]);
    end
  end

endmodule

### hw/rtl/view_matrix_from_euler_yxz_core.sv
// ----------------------------------------------------------------------------
// view_matrix_from_euler_yxz_core
// Camera view matrix (upper 3x4) from position and yaw/pitch/roll, YXZ order.
// ----------------------------------------------------------------------------
// Five-stage pipeline: sine ROM read, two-factor products, triple products
// with clamp, basis-times-position products, dot sum with saturation. One
// transfer is accepted per cycle unless backpressure fills the pipe. Each
// stage has its own valid bit and only holds when the stage ahead is full
// and stalled, so bubbles are squeezed out under backpressure. The sine
// table is a constant ROM of 2^(SINE_INDEX_BITS-2)+1 entries, read twice
// per angle in the first stage.
module view_matrix_from_euler_yxz_core
  import vmfe_pkg::*;
#(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  vmfe_if.sink   in_ch,
  vmfe_if.source out_ch
);

  logic [4:0] vld;
  logic [4:0] rdy;
  stage_en_t  en;
  trig_t      tr;
  basis_t     basis;
  vec_t       pos0, pos1, pos2, pos3;
  out_t       res;

  assign rdy[4] = !vld[4] || out_ch.ready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld[4];
  assign out_ch.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= in_ch.valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
    end
  end

  assign pos0[0] = in_ch.data.pos_x;
  assign pos0[1] = in_ch.data.pos_y;
  assign pos0[2] = in_ch.data.pos_z;

  always_ff @(posedge clk) begin
    if (en.s1) pos1 <= pos0;
    if (en.s2) pos2 <= pos1;
    if (en.s3) pos3 <= pos2;
  end

  // 1 = yaw (angle_y), 2 = pitch (angle_x), 3 = roll (angle_z)
  vmfe_trig #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_trig_yaw (
    .clk(clk), .en(en.s1), .angle(in_ch.data.angle_y), .sin_q(tr.s1), .cos_q(tr.c1)
  );
  vmfe_trig #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_trig_pitch (
    .clk(clk), .en(en.s1), .angle(in_ch.data.angle_x), .sin_q(tr.s2), .cos_q(tr.c2)
  );
  vmfe_trig #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_trig_roll (
    .clk(clk), .en(en.s1), .angle(in_ch.data.angle_z), .sin_q(tr.s3), .cos_q(tr.c3)
  );

  vmfe_basis u_basis (
    .clk(clk), .en_a(en.s2), .en_b(en.s3), .tr(tr), .basis(basis)
  );

  vmfe_translate u_translate (
    .clk(clk), .en_a(en.s4), .en_b(en.s5), .basis(basis), .pos(pos3), .res(res)
  );

endmodule

### tb/view_matrix_from_euler_yxz_core_tb.sv
// ----------------------------------------------------------------------------
// view_matrix_from_euler_yxz_core_tb
// Self-checking bench: directed and random camera poses go through the
// valid/ready channels with random gaps and stalls. Each accepted result is
// checked against a behavioral model of the sine lookup, the YXZ basis and
// the saturated translation.
// ----------------------------------------------------------------------------
module view_matrix_from_euler_yxz_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmfe_pkg::*;

  localparam int IDX_BITS    = 12;
  localparam int QTR_BITS    = IDX_BITS - 2;
  localparam int QTR_SIZE    = 1 << QTR_BITS;
  localparam int RANDOM_POSES = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint Q14     = 16384;

  typedef struct {
    in_t pose;
    bit  drain;   // wait for an empty pipe before this transfer
  } pose_req_t;

  logic clk;
  logic rst;

  vmfe_if #(.T(in_t))  in_ch();
  vmfe_if #(.T(out_t)) out_ch();

  view_matrix_from_euler_yxz_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  longint    sine_rom [QTR_SIZE+1];
  pose_req_t pose_queue [$];
  out_t      matrix_queue [$];
  int        err_count;
  int        cycle_count;
  bit        calm_tx, calm_rx;
  int        tx_gap, rx_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // behavioral model
  // --------------------------------------------------------------------------
  function automatic longint floor14(longint x);
    return x >>> 14;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor14(a * b);
  endfunction

  function automatic longint sine_of(int unsigned ph);
    int unsigned quad, r, idx;
    quad = (ph >> QTR_BITS) & 3;
    r    = ph & (QTR_SIZE - 1);
    idx  = quad[0] ? QTR_SIZE - r : r;
    return quad[1] ? -sine_rom[idx] : sine_rom[idx];
  endfunction

  function automatic void sin_cos(angle_t a, output longint s, output longint c);
    int unsigned ph;
    ph = {16'd0, a} >> (ANGLE_BITS - IDX_BITS);
    s  = sine_of(ph);
    c  = sine_of((ph + QTR_SIZE) & ((1 << IDX_BITS) - 1));
  endfunction

  function automatic longint clamp_basis(longint x);
    if (x > Q14) return Q14;
    if (x < -Q14) return -Q14;
    return x;
  endfunction

  function automatic pos_t view_offset(longint b0, longint b1, longint b2, in_t p);
    longint t;
    t = -floor14(b0 * longint'(p.pos_x) + b1 * longint'(p.pos_y)
                 + b2 * longint'(p.pos_z));
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return pos_t'(t);
  endfunction

  function automatic out_t view_matrix(in_t p);
    longint s1, c1, s2, c2, s3, c3;
    longint m [9];
    out_t   o;
    sin_cos(p.angle_y, s1, c1);
    sin_cos(p.angle_x, s2, c2);
    sin_cos(p.angle_z, s3, c3);
    m[0] = qmul(c1, c3) + qmul(qmul(s1, s2), s3);
    m[1] = qmul(c2, s3);
    m[2] = qmul(qmul(c1, s2), s3) - qmul(c3, s1);
    m[3] = qmul(qmul(c3, s1), s2) - qmul(c1, s3);
    m[4] = qmul(c2, c3);
    m[5] = qmul(qmul(c1, c3), s2) + qmul(s1, s3);
    m[6] = qmul(c2, s1);
    m[7] = -s2;
    m[8] = qmul(c1, c2);
    for (int i = 0; i < 9; i++) m[i] = clamp_basis(m[i]);
    o.u_x = coef_t'(m[0]); o.u_y = coef_t'(m[1]); o.u_z = coef_t'(m[2]);
    o.v_x = coef_t'(m[3]); o.v_y = coef_t'(m[4]); o.v_z = coef_t'(m[5]);
    o.w_x = coef_t'(m[6]); o.w_y = coef_t'(m[7]); o.w_z = coef_t'(m[8]);
    o.trans_u = view_offset(m[0], m[1], m[2], p);
    o.trans_v = view_offset(m[3], m[4], m[5], p);
    o.trans_w = view_offset(m[6], m[7], m[8], p);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return pos_t'($urandom_range(0, 65535)) - 32'sd32768;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 7))
      0: return angle_t'({$urandom_range(0, 7), 13'd0});  // octant boundaries
      1: return angle_t'({$urandom_range(0, 3), 14'h3fff});
      default: return angle_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_pose(pos_t x, pos_t y, pos_t z, angle_t ax, angle_t ay,
                          angle_t az, bit drain);
    pose_req_t r;
    r.pose = '{pos_x: x, pos_y: y, pos_z: z, angle_x: ax, angle_y: ay, angle_z: az};
    r.drain = drain;
    pose_queue.push_back(r);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: one transfer per slot, gaps between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      tx_gap      <= 0;
      calm_tx     <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm_tx <= ~calm_tx;
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pose_queue.size() > 0 &&
                     !(pose_queue[0].drain && matrix_queue.size() > 0)) begin
          pose_req_t r;
          r = pose_queue.pop_front();
          in_ch.data  <= r.pose;
          in_ch.valid <= 1'b1;
          matrix_queue.push_back(view_matrix(r.pose));
          tx_gap <= calm_tx ? 0 : draw_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random backpressure, check each result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_stall     <= 0;
      calm_rx      <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm_rx <= ~calm_rx;
      if (rx_stall > 0) begin
        rx_stall     <= rx_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_stall     <= calm_rx ? 0 : draw_gap();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (matrix_queue.size() == 0) begin
          $error("unexpected result transfer");
          err_count++;
        end else begin
          out_t e, a;
          e = matrix_queue.pop_front();
          a = out_ch.data;
          check_field("u_x", e.u_x, a.u_x);
          check_field("u_y", e.u_y, a.u_y);
          check_field("u_z", e.u_z, a.u_z);
          check_field("v_x", e.v_x, a.v_x);
          check_field("v_y", e.v_y, a.v_y);
          check_field("v_z", e.v_z, a.v_z);
          check_field("w_x", e.w_x, a.w_x);
          check_field("w_y", e.w_y, a.w_y);
          check_field("w_z", e.w_z, a.w_z);
          check_field("trans_u", e.trans_u, a.trans_u);
          check_field("trans_v", e.trans_v, a.trans_v);
          check_field("trans_w", e.trans_w, a.trans_w);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    real th;
    int  v;
    err_count   = 0;
    cycle_count = 0;
    rst         = 1'b1;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      th = 3.14159265358979323846 / 2.0 * k / QTR_SIZE;
      v  = $rtoi(16384.0 * $sin(th) + 0.5);
      sine_rom[k] = (v > Q14) ? Q14 : v;
    end

    // directed: identity, quadrant edges, full-scale positions
    add_pose(0, 0, 0, 0, 0, 0, 0);
    add_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0);
    add_pose(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    add_pose(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             16'sh8000, 16'sh8000, 16'sh8000, 0);
    add_pose(32'sh00010000, 32'shffff0000, 32'sh00020000,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    add_pose(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             16'sh4000, 16'shc000, 16'sh2000, 0);
    add_pose(32'sh12345678, 32'shedcba987, 32'sh00000001,
             16'shc000, 16'sh4000, 16'she000, 0);
    add_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             16'sh2000, 16'sh2000, 16'sh2000, 0);
    add_pose(32'sh80000000, 32'sh80000000, 32'sh80000000,
             16'shd000, 16'sh3000, 16'sh6000, 0);
    // low angle bits fall below the table index
    add_pose(32'sh00008000, 32'sh00008000, 32'sh00008000,
             16'sh000f, 16'sh3fff, 16'sh400f, 0);
    add_pose(32'shffffffff, 32'sh00000001, 32'shffffffff,
             16'sh0010, 16'shbff0, 16'sh7ff0, 1);
    for (int a = 0; a < 8; a++)
      add_pose(rand_pos(), rand_pos(), rand_pos(), angle_t'(a << 13),
               angle_t'((7 - a) << 13), angle_t'((a * 3) << 13), 0);

    for (int n = 0; n < RANDOM_POSES; n++)
      add_pose(rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(),
               rand_angle(), (n % 500) == 250);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pose_queue.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (matrix_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
